/* sv/ohci_pkg.sv */
package ohci_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    localparam logic [5:0] R_REV     = 6'd0;
    localparam logic [5:0] R_CTRL    = 6'd1;
    localparam logic [5:0] R_STAT    = 6'd2;
    localparam logic [5:0] R_ISTAT   = 6'd3;
    localparam logic [5:0] R_IEN     = 6'd4;
    localparam logic [5:0] R_IDIS    = 6'd5;
    localparam logic [5:0] R_HCCA    = 6'd6;
    localparam logic [5:0] R_CTRLCUR = 6'd9;
    localparam logic [5:0] R_BULKCUR = 6'd11;
    localparam logic [5:0] R_DONE    = 6'd12;
    localparam logic [5:0] R_FMNUM   = 6'd15;
    localparam logic [5:0] R_HUBA    = 6'd18;
    localparam logic [5:0] R_PORT0   = 6'd21;
    localparam logic [5:0] R_PORT1   = 6'd22;
    localparam logic [5:0] R_LAST    = 6'd35;
    localparam int         N_PLAIN   = 21;

    localparam logic [1:0] HCFS_RESET = 2'b00;
    localparam logic [1:0] HCFS_OPER  = 2'b10;

    localparam logic [31:0] ST_HCR = 32'h1;
    localparam logic [31:0] ST_CLF = 32'h2;
    localparam logic [31:0] ST_BLF = 32'h4;
    localparam logic [31:0] ST_SOC = 32'h30000;

    localparam logic [31:0] I_WDH  = 32'h2;
    localparam logic [31:0] I_SF   = 32'h4;
    localparam logic [31:0] I_FNO  = 32'h20;
    localparam logic [31:0] I_RHSC = 32'h40;
    localparam logic [31:0] I_MIE  = 32'h8000_0000;

    localparam logic [31:0] P_CCS  = 32'h1;
    localparam logic [31:0] P_PES  = 32'h2;
    localparam logic [31:0] P_PRS  = 32'h10;
    localparam logic [31:0] P_PPS  = 32'h100;
    localparam logic [31:0] P_LSDA = 32'h200;
    localparam logic [31:0] P_CSC  = 32'h10000;
    localparam logic [31:0] P_PESC = 32'h20000;
    localparam logic [31:0] P_PRSC = 32'h100000;
    localparam logic [31:0] P_CHG  = 32'hFF0000;

    localparam logic [31:0] REV_RESET  = 32'h10;
    localparam logic [31:0] HUBA_RESET = 32'h2;
    localparam logic [2:0]  DH_IDLE    = 3'd7;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  reg_index;
        logic [31:0] write_data;
        logic        td_retired;
        logic [31:0] td_retired_addr;
        logic [2:0]  td_delay;
        logic        control_list_worked;
        logic        bulk_list_worked;
        logic        dev0_connected;
        logic        dev0_lowspeed;
        logic        dev1_connected;
        logic        dev1_lowspeed;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_pulse;
        logic        writeback_valid;
        logic [31:0] writeback_done_head;
        logic [15:0] frame_number;
        logic        attach_pulse;
    } t_rsp;

endpackage

/* sv/ohci_if.sv */
interface ohci_req_if;
    import ohci_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ohci_rsp_if;
    import ohci_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/ohci_host_register_and_roothub_top.sv */
// Each accepted request's response is registered in the output register.
// Throughput: one request per cycle; the output register frees as it is drained, so
// input ready stays high while the response slot is empty or being taken.
// Reset (i_rst_n low, synchronous) returns all host registers, timers and the frame counter
// to their reset values; a full-reset write does the same.
module ohci_host_register_and_roothub_top #(
    parameter int PORT_RESET_TICKS    = 10,
    parameter int HUB_CONNECT_TICKS   = 40,
    parameter int HUB_FIRST_PORT_TICK = 20
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ohci_req_if.sink   i_req,
    ohci_rsp_if.source o_rsp
);
    import ohci_pkg::*;

    logic [31:0] r_plain [N_PLAIN];
    logic [31:0] n_plain [N_PLAIN];
    logic [31:0] r_istat, n_istat;
    logic [31:0] r_port [2];
    logic [31:0] n_port [2];
    logic [3:0]  r_prt [2];
    logic [3:0]  n_prt [2];
    logic [5:0]  r_hct, n_hct;
    logic [2:0]  r_dht, n_dht;
    logic [15:0] r_fc, n_fc;
    logic        r_ovalid;
    t_rsp        r_rsp, n_rsp;
    logic        acc;
    t_req        q;

    assign q = i_req.data;
    assign i_req.ready = !r_ovalid || o_rsp.ready;
    assign acc = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data = r_rsp;

    always_comb begin
        logic [31:0] ctrl, ien, s, v;
        logic [31:0] done;
        logic        rst_all, irq;
        logic [1:0]  oldfs, newfs;
        logic        p;
        for (int i = 0; i < N_PLAIN; i++) n_plain[5'(i)] = r_plain[5'(i)];
        n_istat = r_istat;
        n_port = r_port;
        n_prt = r_prt;
        n_hct = r_hct;
        n_dht = r_dht;
        n_fc = r_fc;
        n_rsp = '0;
        rst_all = 1'b0;
        irq = 1'b0;
        v = q.write_data;
        ctrl = r_plain[R_CTRL[4:0]];
        oldfs = ctrl[7:6];
        newfs = v[7:6];
        s = '0;
        p = 1'b0;
        ien = '0;
        done = '0;
        case (t_cmd'(q.command))
            CMD_READ: begin
                if (q.reg_index == R_PORT0 || q.reg_index == R_PORT1) begin
                    n_rsp.read_data = r_port[q.reg_index == R_PORT1];
                end else if (q.reg_index < R_PORT0) begin
                    unique case (q.reg_index)
                        R_STAT:  n_rsp.read_data = '0;
                        R_ISTAT: n_rsp.read_data = r_istat;
                        R_IDIS:  n_rsp.read_data = r_plain[R_IEN[4:0]];
                        R_FMNUM: n_rsp.read_data = {16'd0, r_fc};
                        default: n_rsp.read_data = r_plain[q.reg_index[4:0]];
                    endcase
                end
            end
            CMD_WRITE: begin
                if (q.reg_index == R_PORT0 || q.reg_index == R_PORT1) begin
                    p = (q.reg_index == R_PORT1);
                    s = r_port[p] & ~(v & P_CHG);
                    if ((v & P_PRS) != 0) begin
                        s |= P_PRS;
                        n_prt[p] = 4'(PORT_RESET_TICKS);
                    end
                    if ((v & P_PPS) != 0) begin
                        s |= P_PPS;
                        n_istat |= I_RHSC;
                    end
                    if ((v & P_LSDA) != 0) begin
                        s &= ~P_PPS;
                        n_istat |= I_RHSC;
                    end
                    if ((v & P_PES) != 0) begin
                        s |= P_PES | P_PESC;
                        n_istat |= I_RHSC;
                    end
                    if ((v & P_CCS) != 0) begin
                        s &= ~P_PES;
                        s |= P_PESC;
                        n_istat |= I_RHSC;
                    end
                    n_port[p] = s;
                end else if (q.reg_index < R_PORT0) begin
                    unique case (q.reg_index)
                        R_REV: ;
                        R_CTRL: begin
                            n_plain[R_CTRL[4:0]] = v;
                            if (oldfs != newfs) begin
                                if (newfs == HCFS_OPER) n_hct = 6'(HUB_CONNECT_TICKS);
                                else if (newfs == HCFS_RESET) rst_all = 1'b1;
                            end
                        end
                        R_STAT: begin
                            n_plain[R_STAT[4:0]] = r_plain[R_STAT[4:0]] | (v & ~ST_SOC);
                            if (n_plain[R_STAT[4:0]][0]) rst_all = 1'b1;
                        end
                        R_ISTAT: n_istat = r_istat & ~v;
                        R_IEN:   n_plain[R_IEN[4:0]] = r_plain[R_IEN[4:0]] | v;
                        R_IDIS:  n_plain[R_IEN[4:0]] = r_plain[R_IEN[4:0]] & ~v;
                        R_HCCA:  if (v != 32'hFFFF_FFFF) n_plain[R_HCCA[4:0]] = v;
                        R_FMNUM: n_fc = v[15:0];
                        default: n_plain[q.reg_index[4:0]] = v;
                    endcase
                end
            end
            CMD_TICK: begin
                if (ctrl[7:6] == HCFS_OPER) n_istat |= I_SF;
                if (q.control_list_worked && ctrl[4] && r_plain[R_STAT[4:0]][1]) begin
                    n_plain[R_CTRLCUR[4:0]] = '0;
                    n_plain[R_STAT[4:0]] &= ~ST_CLF;
                end
                if (q.bulk_list_worked && ctrl[5] && r_plain[R_STAT[4:0]][2]) begin
                    n_plain[R_BULKCUR[4:0]] = '0;
                    n_plain[R_STAT[4:0]] &= ~ST_BLF;
                end
                done = r_plain[R_DONE[4:0]];
                if (q.td_retired) begin
                    done = q.td_retired_addr;
                    n_dht = q.td_delay;
                end
                if (r_fc == 16'hFFFF) begin
                    n_fc = '0;
                    n_istat |= I_FNO;
                end else begin
                    n_fc = r_fc + 16'd1;
                end
                ien = r_plain[R_IEN[4:0]];
                if ((n_istat & I_WDH) == 0 && n_dht == 3'd0) begin
                    if (ien[31]) begin
                        irq = 1'b1;
                        done[0] = 1'b1;
                    end
                    n_istat |= I_WDH;
                    n_rsp.writeback_valid = 1'b1;
                    n_rsp.writeback_done_head = done;
                    done = '0;
                    n_dht = DH_IDLE;
                end
                n_plain[R_DONE[4:0]] = done;
                if (ien[31] && (ien & n_istat & (I_RHSC | I_FNO | I_SF)) != 0) irq = 1'b1;
                if (n_dht != 3'd0 && n_dht != DH_IDLE) n_dht = n_dht - 3'd1;
                for (int k = 0; k < 2; k++) begin
                    if (r_prt[1'(k)] != 4'd0) begin
                        n_prt[1'(k)] = r_prt[1'(k)] - 4'd1;
                        if (r_prt[1'(k)] == 4'd1) begin
                            n_port[1'(k)] = (n_port[1'(k)] & ~P_PRS) | P_PRSC;
                            n_istat |= I_RHSC;
                        end
                    end
                end
                if (r_hct != 6'd0) begin
                    n_hct = r_hct - 6'd1;
                    if (n_hct == 6'(HUB_FIRST_PORT_TICK)) begin
                        n_rsp.attach_pulse = 1'b1;
                        n_port[0] = (n_port[0] & ~(P_CCS | P_LSDA | P_PRS))
                            | P_CSC | P_PES | P_PESC | P_PPS | P_PRSC
                            | (q.dev0_connected ? P_CCS : 32'd0)
                            | (q.dev0_lowspeed ? P_LSDA : 32'd0);
                        n_istat |= I_RHSC;
                    end else if (n_hct == 6'd0) begin
                        n_port[1] = (n_port[1] & ~(P_CCS | P_LSDA | P_PRS))
                            | P_CSC | P_PES | P_PESC | P_PPS | P_PRSC
                            | (q.dev1_connected ? P_CCS : 32'd0)
                            | (q.dev1_lowspeed ? P_LSDA : 32'd0);
                        n_istat |= I_RHSC;
                    end
                end
                n_rsp.irq_pulse = irq;
                n_rsp.frame_number = n_fc;
            end
            default: ;
        endcase
        // full reset wipes everything the write just did
        if (rst_all) begin
            for (int i = 0; i < N_PLAIN; i++) n_plain[5'(i)] = '0;
            n_plain[R_REV[4:0]] = REV_RESET;
            n_plain[R_HUBA[4:0]] = HUBA_RESET;
            n_istat = I_RHSC;
            n_port[0] = '0;
            n_port[1] = '0;
            n_prt[0] = '0;
            n_prt[1] = '0;
            n_hct = '0;
            n_dht = '0;
            n_fc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_PLAIN; i++) r_plain[5'(i)] <= '0;
            r_plain[R_REV[4:0]] <= REV_RESET;
            r_plain[R_HUBA[4:0]] <= HUBA_RESET;
            r_istat <= I_RHSC;
            r_port[0] <= '0;
            r_port[1] <= '0;
            r_prt[0] <= '0;
            r_prt[1] <= '0;
            r_hct <= '0;
            r_dht <= '0;
            r_fc <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (acc) begin
                r_plain <= n_plain;
                r_istat <= n_istat;
                r_port <= n_port;
                r_prt <= n_prt;
                r_hct <= n_hct;
                r_dht <= n_dht;
                r_fc <= n_fc;
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_rsp <= n_rsp;
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_rsp.ready |=> r_ovalid && $stable(r_rsp))
        else $error("response changed while stalled");
    a_accept_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_ovalid)
        else $error("accepted request gave no response");
    a_rev_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plain[R_REV[4:0]] == REV_RESET)
        else $error("revision register changed");
    a_wb_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && n_rsp.writeback_valid |=> r_dht == DH_IDLE)
        else $error("done-head timer not parked after write-back");
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
    import ohci_pkg::*;

    localparam int PORT_RESET_TICKS    = 10;
    localparam int HUB_CONNECT_TICKS   = 40;
    localparam int HUB_FIRST_PORT_TICK = 20;
    localparam int WATCHDOG_LIMIT      = 20000;

    logic i_clk;
    logic i_rst_n;
    ohci_req_if req_if ();
    ohci_rsp_if rsp_if ();

    ohci_host_register_and_roothub_top #(
        .PORT_RESET_TICKS(PORT_RESET_TICKS),
        .HUB_CONNECT_TICKS(HUB_CONNECT_TICKS),
        .HUB_FIRST_PORT_TICK(HUB_FIRST_PORT_TICK)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_if.sink),
        .o_rsp(rsp_if.source)
    );

    // shadow of the controller state
    logic [31:0] hc_regs [N_PLAIN];
    logic [31:0] hc_istat;
    logic [31:0] hc_port [2];
    logic [3:0]  hc_prst_timer [2];
    logic [5:0]  hc_hub_timer;
    logic [2:0]  hc_dh_timer;
    logic [15:0] hc_frame;

    t_rsp expected_rsp_q [$];
    int   mismatch_count = 0;
    int   idle_cycles = 0;
    bit   rsp_stall_enable;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void hc_full_reset();
        for (int i = 0; i < N_PLAIN; i++) hc_regs[5'(i)] = '0;
        hc_regs[R_REV[4:0]]  = REV_RESET;
        hc_regs[R_HUBA[4:0]] = HUBA_RESET;
        hc_istat         = I_RHSC;
        hc_port[0]       = '0;
        hc_port[1]       = '0;
        hc_prst_timer[0] = '0;
        hc_prst_timer[1] = '0;
        hc_hub_timer     = '0;
        hc_dh_timer      = '0;
        hc_frame         = '0;
    endfunction

    function automatic void hc_attach(logic p, logic conn, logic low);
        logic [31:0] s;
        s = hc_port[p] & ~(P_CCS | P_LSDA | P_PRS);
        s |= P_CSC | P_PES | P_PESC | P_PPS | P_PRSC;
        if (conn) s |= P_CCS;
        if (low) s |= P_LSDA;
        hc_port[p] = s;
        hc_istat |= I_RHSC;
    endfunction

    function automatic t_rsp hc_predict(t_req r);
        t_rsp o;
        logic [31:0] v;
        logic [31:0] s;
        logic [31:0] ctrl;
        logic [31:0] ien;
        logic [1:0]  old_fs;
        logic p;
        o = '0;
        v = r.write_data;
        if (r.command == CMD_READ && r.reg_index <= R_LAST) begin
            if (r.reg_index == R_PORT0 || r.reg_index == R_PORT1)
                o.read_data = hc_port[r.reg_index == R_PORT1];
            else if (r.reg_index > R_PORT1) o.read_data = '0;
            else if (r.reg_index == R_STAT) o.read_data = '0;
            else if (r.reg_index == R_ISTAT) o.read_data = hc_istat;
            else if (r.reg_index == R_IDIS) o.read_data = hc_regs[R_IEN[4:0]];
            else if (r.reg_index == R_FMNUM) o.read_data = {16'h0, hc_frame};
            else o.read_data = hc_regs[r.reg_index[4:0]];
        end else if (r.command == CMD_WRITE && r.reg_index <= R_LAST) begin
            if (r.reg_index == R_PORT0 || r.reg_index == R_PORT1) begin
                p = (r.reg_index == R_PORT1);
                s = hc_port[p] & ~(v & P_CHG);
                if (v & P_PRS) begin
                    s |= P_PRS;
                    hc_prst_timer[p] = 4'(PORT_RESET_TICKS);
                end
                if (v & P_PPS) begin s |= P_PPS; hc_istat |= I_RHSC; end
                if (v & P_LSDA) begin s &= ~P_PPS; hc_istat |= I_RHSC; end
                if (v & P_PES) begin s |= P_PES | P_PESC; hc_istat |= I_RHSC; end
                if (v & P_CCS) begin
                    s &= ~P_PES;
                    s |= P_PESC;
                    hc_istat |= I_RHSC;
                end
                hc_port[p] = s;
            end else if (r.reg_index < R_PORT0) begin
                case (r.reg_index)
                    R_REV: ;
                    R_CTRL: begin
                        old_fs = hc_regs[R_CTRL[4:0]][7:6];
                        hc_regs[R_CTRL[4:0]] = v;
                        if (old_fs != v[7:6]) begin
                            if (v[7:6] == HCFS_OPER) hc_hub_timer = 6'(HUB_CONNECT_TICKS);
                            else if (v[7:6] == HCFS_RESET) hc_full_reset();
                        end
                    end
                    R_STAT: begin
                        hc_regs[R_STAT[4:0]] |= v & ~ST_SOC;
                        if (hc_regs[R_STAT[4:0]] & ST_HCR) hc_full_reset();
                    end
                    R_ISTAT: hc_istat &= ~v;
                    R_IEN:   hc_regs[R_IEN[4:0]] |= v;
                    R_IDIS:  hc_regs[R_IEN[4:0]] &= ~v;
                    R_HCCA:  if (v != 32'hFFFF_FFFF) hc_regs[R_HCCA[4:0]] = v;
                    R_FMNUM: hc_frame = v[15:0];
                    default: hc_regs[r.reg_index[4:0]] = v;
                endcase
            end
        end else if (r.command == CMD_TICK) begin
            ctrl = hc_regs[R_CTRL[4:0]];
            if (ctrl[7:6] == HCFS_OPER) hc_istat |= I_SF;
            if (r.control_list_worked && ctrl[4] && (hc_regs[R_STAT[4:0]] & ST_CLF)) begin
                hc_regs[R_CTRLCUR[4:0]] = '0;
                hc_regs[R_STAT[4:0]] &= ~ST_CLF;
            end
            if (r.bulk_list_worked && ctrl[5] && (hc_regs[R_STAT[4:0]] & ST_BLF)) begin
                hc_regs[R_BULKCUR[4:0]] = '0;
                hc_regs[R_STAT[4:0]] &= ~ST_BLF;
            end
            if (r.td_retired) begin
                hc_regs[R_DONE[4:0]] = r.td_retired_addr;
                hc_dh_timer = r.td_delay;
            end
            if (hc_frame == 16'hFFFF) hc_istat |= I_FNO;
            hc_frame = hc_frame + 16'd1;
            ien = hc_regs[R_IEN[4:0]];
            if (!(hc_istat & I_WDH) && hc_dh_timer == 0) begin
                if (ien & I_MIE) begin
                    o.irq_pulse = 1'b1;
                    hc_regs[R_DONE[4:0]] |= 32'h1;
                end
                hc_istat |= I_WDH;
                o.writeback_valid = 1'b1;
                o.writeback_done_head = hc_regs[R_DONE[4:0]];
                hc_regs[R_DONE[4:0]] = '0;
                hc_dh_timer = DH_IDLE;
            end
            if ((ien & I_MIE) && (ien & hc_istat & (I_RHSC | I_FNO | I_SF)))
                o.irq_pulse = 1'b1;
            if (hc_dh_timer != 0 && hc_dh_timer != DH_IDLE) hc_dh_timer--;
            for (int q = 0; q < 2; q++) begin
                if (hc_prst_timer[1'(q)] != 0) begin
                    hc_prst_timer[1'(q)]--;
                    if (hc_prst_timer[1'(q)] == 0) begin
                        hc_port[1'(q)] = (hc_port[1'(q)] & ~P_PRS) | P_PRSC;
                        hc_istat |= I_RHSC;
                    end
                end
            end
            if (hc_hub_timer != 0) begin
                hc_hub_timer--;
                if (hc_hub_timer == 6'(HUB_FIRST_PORT_TICK)) begin
                    o.attach_pulse = 1'b1;
                    hc_attach(1'b0, r.dev0_connected, r.dev0_lowspeed);
                end else if (hc_hub_timer == 0) begin
                    hc_attach(1'b1, r.dev1_connected, r.dev1_lowspeed);
                end
            end
            o.frame_number = hc_frame;
        end
        return o;
    endfunction

    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_request(t_req r);
        int gap;
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        expected_rsp_q.push_back(hc_predict(r));
        gap = gap_len();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_req rand_fields();
        t_req r;
        r.command             = t_cmd'($urandom_range(0, 3));
        r.reg_index           = 6'($urandom_range(0, 63));
        r.write_data          = $urandom();
        r.td_retired          = 1'($urandom_range(0, 1));
        r.td_retired_addr     = $urandom();
        r.td_delay            = 3'($urandom_range(0, 7));
        r.control_list_worked = 1'($urandom_range(0, 1));
        r.bulk_list_worked    = 1'($urandom_range(0, 1));
        r.dev0_connected      = 1'($urandom_range(0, 1));
        r.dev0_lowspeed       = 1'($urandom_range(0, 1));
        r.dev1_connected      = 1'($urandom_range(0, 1));
        r.dev1_lowspeed       = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic reg_access(t_cmd c, logic [5:0] idx, logic [31:0] v);
        t_req r;
        r = rand_fields();
        r.command    = c;
        r.reg_index  = idx;
        r.write_data = v;
        send_request(r);
    endtask

    task automatic frame_tick();
        t_req r;
        r = rand_fields();
        r.command = CMD_TICK;
        send_request(r);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_register_map();
        reg_access(CMD_READ, R_REV, '0);
        reg_access(CMD_WRITE, R_REV, 32'hFFFF_FFFF);
        reg_access(CMD_READ, R_REV, '0);
        reg_access(CMD_WRITE, R_HCCA, 32'hFFFF_FFFF);
        reg_access(CMD_WRITE, R_HCCA, 32'h1234_5600);
        reg_access(CMD_READ, R_HCCA, '0);
        reg_access(CMD_WRITE, R_STAT, 32'hFFFF_FFFE);
        reg_access(CMD_READ, R_STAT, '0);
        reg_access(CMD_WRITE, R_IEN, 32'hFFFF_FFFF);
        reg_access(CMD_WRITE, R_IDIS, 32'h0000_00F0);
        reg_access(CMD_READ, R_IDIS, '0);
        reg_access(CMD_WRITE, R_FMNUM, 32'hABCD_FFFE);
        frame_tick();
        frame_tick();
        reg_access(CMD_READ, R_ISTAT, '0);
        reg_access(CMD_WRITE, R_ISTAT, 32'hFFFF_FFFF);
        reg_access(CMD_WRITE, 6'd30, 32'hFFFF_FFFF);
        reg_access(CMD_READ, 6'd35, '0);
        reg_access(CMD_READ, 6'd63, '0);
        reg_access(CMD_WRITE, 6'd63, 32'hFFFF_FFFF);
        reg_access(CMD_NOP, R_CTRL, 32'hFFFF_FFFF);
        reg_access(CMD_WRITE, R_STAT, ST_HCR);
        reg_access(CMD_READ, R_HUBA, '0);
    endtask

    task automatic test_root_hub();
        reg_access(CMD_WRITE, R_CTRL, 32'h80);
        repeat (HUB_CONNECT_TICKS + 2) frame_tick();
        reg_access(CMD_WRITE, R_PORT0, P_PRS | P_PPS);
        reg_access(CMD_WRITE, R_PORT1, P_PES | P_LSDA | P_CCS);
        repeat (PORT_RESET_TICKS + 1) frame_tick();
        reg_access(CMD_READ, R_PORT0, '0);
        reg_access(CMD_WRITE, R_PORT0, P_CHG);
        reg_access(CMD_READ, R_PORT1, '0);
        reg_access(CMD_WRITE, R_CTRL, 32'h0);
        wait_drained();
    endtask

    task automatic test_random_traffic(int n);
        t_req r;
        int sel;
        for (int i = 0; i < n; i++) begin
            r = rand_fields();
            sel = $urandom_range(0, 99);
            if (sel < 40) r.command = CMD_TICK;
            else if (sel < 70) r.command = CMD_READ;
            else if (sel < 97) r.command = CMD_WRITE;
            // keep full resets rare so the timers get to run out
            if (r.command == CMD_WRITE && r.reg_index == R_CTRL && $urandom_range(0, 3) != 0)
                r.write_data[7:6] = HCFS_OPER;
            if (r.command == CMD_WRITE && r.reg_index == R_STAT && $urandom_range(0, 7) != 0)
                r.write_data[0] = 1'b0;
            if (r.reg_index > R_LAST && $urandom_range(0, 3) != 0)
                r.reg_index = 6'($urandom_range(0, 22));
            send_request(r);
            if (i == n / 2) begin
                // hold off until every response is back
                wait_drained();
                rsp_stall_enable = (n % 2) == 0;
            end
        end
    endtask

    // response side: random stalls when enabled, compare against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_rsp_q.size() == 0) begin
                    $display("%0t: unexpected response %h", $time, rsp_if.data);
                    mismatch_count++;
                end else begin
                    t_rsp e;
                    e = expected_rsp_q.pop_front();
                    if (e.read_data !== rsp_if.data.read_data ||
                        e.irq_pulse !== rsp_if.data.irq_pulse ||
                        e.writeback_valid !== rsp_if.data.writeback_valid ||
                        e.writeback_done_head !== rsp_if.data.writeback_done_head ||
                        e.frame_number !== rsp_if.data.frame_number ||
                        e.attach_pulse !== rsp_if.data.attach_pulse) begin
                        $display("%0t: expected %h actual %h", $time, e, rsp_if.data);
                        mismatch_count++;
                    end
                end
            end
            rsp_if.ready <= rsp_stall_enable ? ($urandom_range(0, 99) < 70) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        rsp_stall_enable = 1'b1;
        req_if.valid     = 1'b0;
        req_if.data      = '0;
        i_rst_n          = 1'b0;
        hc_full_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_map();
        test_root_hub();
        rsp_stall_enable = 1'b0;
        test_random_traffic(700);
        rsp_stall_enable = 1'b1;
        test_random_traffic(700);
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_rsp_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

/* sim.f */
sv/ohci_pkg.sv
sv/ohci_if.sv
sv/ohci_host_register_and_roothub_top.sv
tb/tb.sv
